FILE: rtl/hrrn_pkg.sv
package hrrn_pkg;

  localparam int unsigned NumSlots = 64;
  localparam int unsigned SlotW = $clog2(NumSlots);
  localparam int unsigned TimeW = 32;
  localparam int unsigned BurstW = 24;
  localparam int unsigned IdW = 16;
  localparam int unsigned ProdW = TimeW + BurstW;

  localparam logic ModeEnqueue = 1'b0;
  localparam logic ModeDispatch = 1'b1;

  // One stored process entry, handed down the chain during a scan
  typedef struct packed {
    logic [TimeW-1:0]  ready_time;
    logic [BurstW-1:0] burst;
    logic [TimeW-1:0]  arrival;
    logic [IdW-1:0]    pid;
    logic [BurstW-1:0] remaining;
  } entry_t;

  // Control from the sequencer to the cells
  typedef struct packed {
    logic             write;
    logic [SlotW-1:0] write_slot;
    logic             rotate;
    logic             clear_head;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StOut  = 3'b100
  } state_e;

endpackage

FILE: rtl/hrrn_cell.sv
// One slot of the ring. On rotate it takes its left neighbor's entry and flag.
module hrrn_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                write_i,
  input  logic                rotate_i,
  input  logic                clear_i,
  input  hrrn_pkg::entry_t    entry_i,
  input  hrrn_pkg::entry_t    prev_entry_i,
  input  logic                prev_ready_i,
  output hrrn_pkg::entry_t    entry_o,
  output logic                ready_o
);

  hrrn_pkg::entry_t entry_q;
  logic             ready_q;

  // Hold payload; load on write, shift on rotate
  always_ff @(posedge clk_i) begin
    if (write_i) begin
      entry_q <= entry_i;
    end else if (rotate_i) begin
      entry_q <= prev_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
    end else if (write_i) begin
      ready_q <= 1'b1;
    end else if (rotate_i) begin
      ready_q <= prev_ready_i;
    end else if (clear_i) begin
      ready_q <= 1'b0;
    end
  end

  assign entry_o = entry_q;
  assign ready_o = ready_q;

endmodule

FILE: rtl/hrrn_ring.sv
// Ring of cells. Rotation moves every entry down one place; after NumSlots
// rotations each entry is home again. Cell 0's output is the scan head.
module hrrn_ring (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  hrrn_pkg::cell_ctrl_t               ctrl_i,
  input  logic [hrrn_pkg::SlotW-1:0]         clear_slot_i,
  input  hrrn_pkg::entry_t                   entry_i,
  output hrrn_pkg::entry_t                   head_entry_o,
  output logic                               head_ready_o
);

  hrrn_pkg::entry_t entries [hrrn_pkg::NumSlots];
  logic [hrrn_pkg::NumSlots-1:0] ready;

  for (genvar g = 0; g < hrrn_pkg::NumSlots; g++) begin : g_cell
    localparam int unsigned Prev = (g + 1) % hrrn_pkg::NumSlots;
    localparam logic [hrrn_pkg::SlotW-1:0] SlotIdx = hrrn_pkg::SlotW'(g);
    hrrn_cell u_cell (
      .clk_i,
      .rst_ni,
      .write_i      (ctrl_i.write && ctrl_i.write_slot == SlotIdx),
      .rotate_i     (ctrl_i.rotate),
      .clear_i      (ctrl_i.clear_head && clear_slot_i == SlotIdx),
      .entry_i      (entry_i),
      .prev_entry_i (entries[Prev]),
      .prev_ready_i (ready[Prev]),
      .entry_o      (entries[g]),
      .ready_o      (ready[g])
    );
  end

  // Scan reads cell 0, which feeds the last cell on rotate
  assign head_entry_o = entries[0];
  assign head_ready_o = ready[0];

endmodule

FILE: rtl/hrrn_dispatch_selector_top.sv
// Enqueue: the word is written into its slot, no result word; enqueues can run one per cycle
// while the selector is idle and holds no result word. Dispatch: a scan of all NumSlots slots
// (one slot per cycle through a single cross-multiply comparator as the cell ring rotates),
// then the StOut state loads the output register, which holds the result word.
// Input holds off until that word is taken.
// Reset (rst_ni low, async) clears all ready flags and the control state.
module hrrn_dispatch_selector_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic        mode_i,
  input  logic [31:0] current_time_i,
  input  logic [5:0]  process_index_i,
  input  logic [23:0] burst_length_i,
  input  logic [31:0] arrival_time_i,
  input  logic [15:0] process_id_i,
  input  logic [23:0] remaining_time_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic        found_o,
  output logic [5:0]  chosen_process_o,
  output logic [23:0] chosen_length_o
);

  localparam int unsigned SlotW = hrrn_pkg::SlotW;
  localparam int unsigned TimeW = hrrn_pkg::TimeW;
  localparam int unsigned BurstW = hrrn_pkg::BurstW;
  localparam int unsigned ProdW = hrrn_pkg::ProdW;

  hrrn_pkg::state_e state_q, state_d;
  logic [SlotW:0]       cnt_q;
  logic [TimeW-1:0]     now_q;
  logic                 have_q;
  logic [SlotW-1:0]     best_q;
  logic [TimeW-1:0]     best_wait_q;
  logic [BurstW-1:0]    best_burst_q;
  logic [TimeW-1:0]     best_arr_q;
  logic [hrrn_pkg::IdW-1:0] best_id_q;
  logic [BurstW-1:0]    best_rem_q;
  logic                 out_valid_q;
  logic                 out_found_q;
  logic [SlotW-1:0]     out_slot_q;
  logic [BurstW-1:0]    out_len_q;

  hrrn_pkg::cell_ctrl_t ctrl;
  hrrn_pkg::entry_t     in_entry, head;
  logic                 head_ready;
  logic                 accept;

  assign ready_o = (state_q == hrrn_pkg::StIdle) && !out_valid_q;
  assign accept  = valid_i && ready_o;

  assign in_entry = '{ready_time: current_time_i, burst: burst_length_i,
                      arrival: arrival_time_i, pid: process_id_i,
                      remaining: remaining_time_i};

  // Head slot index: the entry at cell 0 after cnt - 1 rotations came
  // from slot cnt - 1
  logic [SlotW-1:0] head_slot;
  assign head_slot = cnt_q[SlotW-1:0] - SlotW'(1);

  // Waited time and effective burst of the head entry
  logic [TimeW-1:0]  head_wait;
  logic [BurstW-1:0] head_burst;
  assign head_wait  = (now_q >= head.ready_time) ? now_q - head.ready_time : '0;
  assign head_burst = (head.burst == '0) ? BurstW'(1) : head.burst;

  logic [ProdW-1:0] lhs, rhs;
  logic             beats;
  assign lhs = ProdW'(head_wait) * ProdW'(best_burst_q);
  assign rhs = ProdW'(best_wait_q) * ProdW'(head_burst);
  always_comb begin
    if (lhs != rhs)                 beats = lhs > rhs;
    else if (head.arrival != best_arr_q) beats = head.arrival < best_arr_q;
    else                            beats = head.pid < best_id_q;
  end

  logic scanning, take;
  assign scanning = (state_q == hrrn_pkg::StScan);
  assign take     = scanning && head_ready && (!have_q || beats);

  // Drive the ring: write on enqueue, rotate through the scan, clear winner
  always_comb begin
    ctrl.write      = accept && mode_i == hrrn_pkg::ModeEnqueue;
    ctrl.write_slot = process_index_i;
    ctrl.rotate     = scanning;
    ctrl.clear_head = (state_q == hrrn_pkg::StOut) && have_q;
  end

  hrrn_ring u_ring (
    .clk_i,
    .rst_ni,
    .ctrl_i       (ctrl),
    .clear_slot_i (best_q),
    .entry_i      (in_entry),
    .head_entry_o (head),
    .head_ready_o (head_ready)
  );

  // Sequence: idle, scan all slots, publish
  always_comb begin
    state_d = state_q;
    case (state_q)
      hrrn_pkg::StIdle:
        if (accept && mode_i == hrrn_pkg::ModeDispatch) state_d = hrrn_pkg::StScan;
      hrrn_pkg::StScan:
        if (cnt_q == (SlotW+1)'(hrrn_pkg::NumSlots)) state_d = hrrn_pkg::StOut;
      hrrn_pkg::StOut: state_d = hrrn_pkg::StIdle;
      default: state_d = hrrn_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hrrn_pkg::StIdle;
      cnt_q       <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        cnt_q  <= (SlotW+1)'(1);
        have_q <= 1'b0;
      end else if (scanning && cnt_q != (SlotW+1)'(hrrn_pkg::NumSlots)) begin
        cnt_q <= cnt_q + (SlotW+1)'(1);
      end
      if (take) have_q <= 1'b1;
      if (state_q == hrrn_pkg::StOut) out_valid_q <= 1'b1;
      else if (ready_i) out_valid_q <= 1'b0;
    end
  end

  // Hold the running best and the result word
  always_ff @(posedge clk_i) begin
    if (accept) now_q <= current_time_i;
    if (take) begin
      best_q       <= head_slot;
      best_wait_q  <= head_wait;
      best_burst_q <= head_burst;
      best_arr_q   <= head.arrival;
      best_id_q    <= head.pid;
      best_rem_q   <= head.remaining;
    end
    if (state_q == hrrn_pkg::StOut) begin
      out_found_q <= have_q;
      out_slot_q  <= have_q ? best_q : '0;
      out_len_q   <= have_q ? best_rem_q : '0;
    end
  end

  assign valid_o          = out_valid_q;
  assign found_o          = out_found_q;
  assign chosen_process_o = out_slot_q;
  assign chosen_length_o  = out_len_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != hrrn_pkg::StIdle |-> !accept) else $error("accept while busy");
  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hrrn_pkg::StOut |=> valid_o) else $error("no result after scan");
  a_take_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> head_ready) else $error("picked idle slot");

endmodule

FILE: tb/hrrn_dispatch_selector_top_tb.sv
`timescale 1ns / 1ps

module hrrn_dispatch_selector_top_tb;

  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [23:0] length;
  } pick_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic        mode_i;
  logic [31:0] current_time_i;
  logic [5:0]  process_index_i;
  logic [23:0] burst_length_i;
  logic [31:0] arrival_time_i;
  logic [15:0] process_id_i;
  logic [23:0] remaining_time_i;
  logic        valid_o;
  logic        ready_i;
  logic        found_o;
  logic [5:0]  chosen_process_o;
  logic [23:0] chosen_length_o;

  // Shadow copy of the slot table
  logic        slot_ready[64];
  logic [31:0] slot_ready_time[64];
  logic [23:0] slot_burst[64];
  logic [31:0] slot_arrival[64];
  logic [15:0] slot_pid[64];
  logic [23:0] slot_remaining[64];

  pick_t       pending_picks[$];
  int          mismatches;
  bit          idle_en;
  bit          hold_req;
  logic [31:0] sim_now;

  hrrn_dispatch_selector_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (valid_i),
    .ready_o          (ready_o),
    .mode_i           (mode_i),
    .current_time_i   (current_time_i),
    .process_index_i  (process_index_i),
    .burst_length_i   (burst_length_i),
    .arrival_time_i   (arrival_time_i),
    .process_id_i     (process_id_i),
    .remaining_time_i (remaining_time_i),
    .valid_o          (valid_o),
    .ready_i          (ready_i),
    .found_o          (found_o),
    .chosen_process_o (chosen_process_o),
    .chosen_length_o  (chosen_length_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [63:0] waited(logic [31:0] now, int k);
    return (now >= slot_ready_time[k]) ? 64'(now - slot_ready_time[k]) : 64'd0;
  endfunction

  function automatic logic [63:0] eff_burst(int k);
    return (slot_burst[k] == 24'd0) ? 64'd1 : 64'(slot_burst[k]);
  endfunction

  // True if slot a outranks slot b at time now
  function automatic bit outranks(logic [31:0] now, int a, int b);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = waited(now, a) * eff_burst(b);
    rhs = waited(now, b) * eff_burst(a);
    if (lhs != rhs) return lhs > rhs;
    if (slot_arrival[a] != slot_arrival[b]) return slot_arrival[a] < slot_arrival[b];
    return slot_pid[a] < slot_pid[b];
  endfunction

  // Pick the highest response ratio slot and retire it
  function automatic pick_t pick_best(logic [31:0] now);
    pick_t p;
    int    best;
    best = -1;
    for (int k = 0; k < 64; k++) begin
      if (slot_ready[k] && (best < 0 || outranks(now, k, best))) best = k;
    end
    p = '0;
    if (best >= 0) begin
      slot_ready[best] = 1'b0;
      p.found  = 1'b1;
      p.slot   = 6'(best);
      p.length = slot_remaining[best];
    end
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("[%0t] mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  // Send one word, then update the shadow table once it is taken
  task automatic send_word(logic mode, logic [31:0] now, logic [5:0] idx, logic [23:0] burst,
                           logic [31:0] arr, logic [15:0] pid, logic [23:0] rem);
    valid_i          <= 1'b1;
    mode_i           <= mode;
    current_time_i   <= now;
    process_index_i  <= idx;
    burst_length_i   <= burst;
    arrival_time_i   <= arr;
    process_id_i     <= pid;
    remaining_time_i <= rem;
    do @(posedge clk_i); while (!ready_o);
    if (mode == hrrn_pkg::ModeDispatch) begin
      pending_picks.push_back(pick_best(now));
    end else begin
      slot_ready[idx]      = 1'b1;
      slot_ready_time[idx] = now;
      slot_burst[idx]      = burst;
      slot_arrival[idx]    = arr;
      slot_pid[idx]        = pid;
      slot_remaining[idx]  = rem;
    end
    if (idle_en && $urandom_range(0, 5) == 0) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic enqueue(logic [31:0] now, logic [5:0] idx, logic [23:0] burst,
                         logic [31:0] arr, logic [15:0] pid, logic [23:0] rem);
    send_word(hrrn_pkg::ModeEnqueue, now, idx, burst, arr, pid, rem);
  endtask

  task automatic dispatch(logic [31:0] now);
    send_word(hrrn_pkg::ModeDispatch, now, 6'($urandom), 24'($urandom), $urandom,
              16'($urandom), 24'($urandom));
  endtask

  // Random word: mostly well-formed traffic on a rising clock, some noise
  task automatic random_word();
    logic [23:0] burst;
    logic [31:0] arr;
    logic [31:0] now;
    sim_now += $urandom_range(0, 200);
    now = ($urandom_range(0, 19) == 0) ? $urandom : sim_now;
    case ($urandom_range(0, 3))
      0:       burst = 24'($urandom);
      1:       burst = ($urandom_range(0, 9) == 0) ? 24'd0 : 24'hFFFFFF;
      default: burst = 24'($urandom_range(1, 8));
    endcase
    arr = ($urandom_range(0, 2) == 0) ? $urandom : 32'($urandom_range(0, 3));
    if ($urandom_range(0, 9) < 4) begin
      dispatch(now);
    end else begin
      enqueue(now, 6'($urandom), burst, arr,
              ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 3)),
              24'($urandom));
    end
  endtask

  task automatic test_directed();
    dispatch(32'd0);
    enqueue(32'd0, 6'd0, 24'hFFFFFF, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF);
    enqueue(32'hFFFFFFFF, 6'd63, 24'd1, 32'd0, 16'd0, 24'd0);
    // Clock behind slot 63's ready time: its wait saturates at zero
    dispatch(32'd100);
    dispatch(32'hFFFFFFFF);
    // Zero burst counts as one
    enqueue(32'd10, 6'd1, 24'd0, 32'd5, 16'd1, 24'h000123);
    enqueue(32'd10, 6'd2, 24'd2, 32'd5, 16'd1, 24'h000456);
    dispatch(32'd20);
    dispatch(32'd20);
    // Re-enqueue overwrites and stays ready once
    enqueue(32'd0, 6'd3, 24'd4, 32'd0, 16'd7, 24'h111111);
    enqueue(32'd8, 6'd3, 24'd3, 32'd1, 16'd8, 24'h222222);
    dispatch(32'd50);
    dispatch(32'd50);
    // Equal ratio: arrival decides, then id, then lowest slot
    enqueue(32'd0, 6'd40, 24'd2, 32'd9, 16'd3, 24'h0000AA);
    enqueue(32'd0, 6'd41, 24'd4, 32'd8, 16'd3, 24'h0000BB);
    enqueue(32'd0, 6'd9,  24'd2, 32'd8, 16'd2, 24'h0000CC);
    enqueue(32'd0, 6'd5,  24'd2, 32'd8, 16'd2, 24'h0000DD);
    repeat (5) dispatch(32'd40);
  endtask

  task automatic test_random(int n);
    repeat (n) random_word();
  endtask

  // Stall the result side for a long stretch while words keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) random_word();
  endtask

  task automatic drain();
    int guard;
    valid_i <= 1'b0;
    guard = 0;
    while (pending_picks.size() != 0 && guard < 100_000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  // Result side: random stall bursts plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 600;
      end else if (stall_left == 0 && idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 19);
      end
      if (stall_left > 0) begin
        stall_left--;
        ready_i <= 1'b0;
      end else begin
        ready_i <= 1'b1;
      end
    end
  end

  // Compare each taken result with the oldest pending pick
  always @(posedge clk_i) begin
    pick_t want;
    if (rst_ni && valid_o && ready_i) begin
      if (pending_picks.size() == 0) begin
        report("unexpected word", 32'(chosen_process_o), 32'd0);
      end else begin
        want = pending_picks.pop_front();
        if (found_o !== want.found) report("found", 32'(found_o), 32'(want.found));
        if (chosen_process_o !== want.slot)
          report("chosen_process", 32'(chosen_process_o), 32'(want.slot));
        if (chosen_length_o !== want.length)
          report("chosen_length", 32'(chosen_length_o), 32'(want.length));
      end
    end
  end

  initial begin
    mismatches = 0;
    idle_en = 1'b1;
    hold_req = 1'b0;
    sim_now = 32'd1000;
    for (int k = 0; k < 64; k++) slot_ready[k] = 1'b0;
    rst_ni <= 1'b0;
    valid_i <= 1'b0;
    mode_i <= hrrn_pkg::ModeEnqueue;
    current_time_i <= '0;
    process_index_i <= '0;
    burst_length_i <= '0;
    arrival_time_i <= '0;
    process_id_i <= '0;
    remaining_time_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(1300);
    test_backpressure();
    test_random(150);
    idle_en = 1'b0;
    test_random(150);
    drain();

    if (mismatches == 0 && pending_picks.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
